// ===== src/trrs_pkg.sv =====
// Shared types and constants for the two-level round-robin scheduler.
// Request and response payload structs, command codes, register indexes.
// No dependencies.
package trrs_pkg;

	localparam int TIME_FIELD_W  = 16;
	localparam int INDEX_FIELD_W = 5;
	localparam int COUNT_FIELD_W = 6;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_IDX_W     = 2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_GRANT = 1'b1;

	localparam logic CLASS_LOW  = 1'b0;
	localparam logic CLASS_HIGH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_SLICE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_COUNT  = 2'd2;

	typedef struct packed {
		logic                     command;
		logic                     priority_class;
		logic [INDEX_FIELD_W-1:0] process_index;
		logic [TIME_FIELD_W-1:0]  burst_time;
	} req_t;

	typedef struct packed {
		logic                     grant_valid;
		logic                     granted_class;
		logic [INDEX_FIELD_W-1:0] granted_index;
		logic [TIME_FIELD_W-1:0]  granted_time;
		logic                     finished;
		logic                     all_done;
	} rsp_t;

endpackage

// ===== src/trrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the remaining-time tables; no dependencies.
module trrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/two_level_round_robin_scheduler_core.sv =====
// Two-level round-robin time-slice scheduler, top level. Uses trrs_pkg, trrs_ram.
// A load passes through LOAD and RESP. A grant scans the high table, then the low
// table if nothing is found, in SCAN, updates the entry it hits in CALC, and answers
// from RESP. A table whose count is zero has no entries to examine. The scan
// steps one entry per cycle; a single subtract/compare unit then updates the entry.
// One request is in flight at a time; the next one is taken once the block is back
// in idle, even while the previous response waits. After reset all table entries
// read as zero (per-entry nonzero flags are cleared); no clearing pass is needed.
module two_level_round_robin_scheduler_core
	import trrs_pkg::*;
#(
	parameter int MAX_PROCESSES = 32,
	parameter int TIME_WIDTH    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W  = $clog2(MAX_PROCESSES);
	localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
	localparam int ADDR_W = IDX_W + 1;
	localparam int CMP_W  = ((TIME_WIDTH > TIME_FIELD_W) ? TIME_WIDTH : TIME_FIELD_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_CALC,
		ST_RESP
	} state_t;

	state_t state_q;

	logic [TIME_FIELD_W-1:0]  time_slice_q;
	logic [COUNT_FIELD_W-1:0] high_count_q;
	logic [COUNT_FIELD_W-1:0] low_count_q;

	req_t                            item_q;
	logic [CNT_W-1:0]                hc_q;
	logic [CNT_W-1:0]                lc_q;
	logic [IDX_W-1:0]                hp_q;
	logic [IDX_W-1:0]                lp_q;
	logic                            cls_q;
	logic [IDX_W-1:0]                e_q;
	logic [CNT_W-1:0]                k_q;
	logic [1:0][MAX_PROCESSES-1:0]   nz_q;
	rsp_t                            res_q;
	rsp_t                            rsp_q;
	logic                            rsp_valid_q;

	// clamped counts from the config registers
	logic [CNT_W-1:0] hc_clamp;
	logic [CNT_W-1:0] lc_clamp;

	assign hc_clamp = (int'(high_count_q) > MAX_PROCESSES) ? CNT_W'(MAX_PROCESSES)
	                                                       : CNT_W'(high_count_q);
	assign lc_clamp = (int'(low_count_q) > MAX_PROCESSES) ? CNT_W'(MAX_PROCESSES)
	                                                      : CNT_W'(low_count_q);

	// scan bookkeeping
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] e_next;
	logic [IDX_W-1:0] e_wrap;
	logic [IDX_W-1:0] lo_start;
	logic             hit;

	assign cnt      = cls_q ? hc_q : lc_q;
	assign e_next   = CNT_W'(e_q) + 1'b1;
	assign e_wrap   = (e_next < cnt) ? IDX_W'(e_next) : '0;
	assign lo_start = (CNT_W'(lp_q) < lc_q) ? lp_q : '0;
	assign hit      = nz_q[cls_q][e_q];

	// load path
	logic [IDX_W-1:0]      ld_idx;
	logic                  ld_ok;
	logic [TIME_WIDTH-1:0] ld_val;

	assign ld_idx = IDX_W'(item_q.process_index);
	assign ld_ok  = int'(item_q.process_index) < MAX_PROCESSES;
	assign ld_val = TIME_WIDTH'(item_q.burst_time);

	// shared subtract/compare unit
	logic [TIME_WIDTH-1:0]   rd_data;
	logic [TIME_FIELD_W-1:0] slice;
	logic [CMP_W-1:0]        diff;
	logic                    gt;
	logic [TIME_WIDTH-1:0]   new_rem;
	logic [CMP_W-1:0]        amt;

	assign slice   = (time_slice_q == '0) ? TIME_FIELD_W'(1) : time_slice_q;
	assign diff    = CMP_W'(rd_data) - CMP_W'(slice);
	assign gt      = !diff[CMP_W-1] && (diff != '0);
	assign new_rem = gt ? diff[TIME_WIDTH-1:0] : '0;
	assign amt     = gt ? CMP_W'(slice) : CMP_W'(rd_data);

	// any time left in either table, within the counts
	logic any_left;

	always_comb begin
		any_left = 1'b0;
		for (int i = 0; i < MAX_PROCESSES; i++) begin
			if (i < int'(hc_q) && nz_q[CLASS_HIGH][i]) begin
				any_left = 1'b1;
			end
			if (i < int'(lc_q) && nz_q[CLASS_LOW][i]) begin
				any_left = 1'b1;
			end
		end
	end

	rsp_t rsp_next;

	always_comb begin
		rsp_next          = res_q;
		rsp_next.all_done = !any_left;
	end

	// table RAM, addressed by {class, index}
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [TIME_WIDTH-1:0] ram_wdata;

	assign ram_we    = (state_q == ST_LOAD && ld_ok) || (state_q == ST_CALC);
	assign ram_waddr = (state_q == ST_LOAD) ? {item_q.priority_class, ld_idx} : {cls_q, e_q};
	assign ram_wdata = (state_q == ST_LOAD) ? ld_val : new_rem;

	trrs_ram #(
		.WIDTH(TIME_WIDTH),
		.DEPTH(2 ** ADDR_W)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr({cls_q, e_q}),
		.rdata(rd_data)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			time_slice_q <= TIME_FIELD_W'(1);
			high_count_q <= '0;
			low_count_q  <= '0;
			item_q       <= '0;
			hc_q         <= '0;
			lc_q         <= '0;
			hp_q         <= '0;
			lp_q         <= '0;
			cls_q        <= CLASS_HIGH;
			e_q          <= '0;
			k_q          <= '0;
			nz_q         <= '0;
			res_q        <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIME_SLICE: time_slice_q <= cfg_data;
					REG_HIGH_COUNT: high_count_q <= cfg_data[COUNT_FIELD_W-1:0];
					REG_LOW_COUNT:  low_count_q  <= cfg_data[COUNT_FIELD_W-1:0];
					default: ;
				endcase
			end

			if (rsp_valid_q && !rsp_stall && state_q != ST_RESP) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						item_q <= req;
						hc_q   <= hc_clamp;
						lc_q   <= lc_clamp;
						res_q  <= '0;
						k_q    <= '0;
						cls_q  <= CLASS_HIGH;
						e_q    <= (CNT_W'(hp_q) < hc_clamp) ? hp_q : '0;
						state_q <= (req.command == CMD_LOAD) ? ST_LOAD : ST_SCAN;
					end
				end
				ST_LOAD: begin
					if (ld_ok) begin
						nz_q[item_q.priority_class][ld_idx] <= (ld_val != '0);
					end
					state_q <= ST_RESP;
				end
				ST_SCAN: begin
					if (cnt != '0 && hit) begin
						// read data for {cls, e} lands in the RAM output register now
						state_q <= ST_CALC;
					end else if (cnt == '0 || k_q == cnt - 1'b1) begin
						if (cls_q == CLASS_HIGH) begin
							cls_q <= CLASS_LOW;
							e_q   <= lo_start;
							k_q   <= '0;
						end else begin
							state_q <= ST_RESP;
						end
					end else begin
						e_q <= e_wrap;
						k_q <= k_q + 1'b1;
					end
				end
				ST_CALC: begin
					nz_q[cls_q][e_q]    <= gt;
					res_q.grant_valid   <= 1'b1;
					res_q.granted_class <= cls_q;
					res_q.granted_index <= INDEX_FIELD_W'(e_q);
					res_q.granted_time  <= amt[TIME_FIELD_W-1:0];
					res_q.finished      <= !gt;
					if (cls_q == CLASS_HIGH) begin
						hp_q <= e_wrap;
					end else begin
						lp_q <= e_wrap;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= rsp_next;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scan position stays inside the active table
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && cnt != '0 |-> k_q < cnt && CNT_W'(e_q) < cnt)
		else $error("scan index outside table count");

	// a hit from the flags must find real time in the RAM
	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC |-> rd_data != '0)
		else $error("flag set for an entry holding no time");

	// a finishing grant clears its flag
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC && !gt |=> !nz_q[$past(cls_q)][$past(e_q)])
		else $error("finished entry still flagged");

	// a grant that leaves nothing behind must have finished its process
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.grant_valid && rsp.all_done |-> rsp.finished)
		else $error("all done reported after an unfinished grant");

endmodule

// ===== test/two_level_round_robin_scheduler_core_tb.sv =====
// Self-checking testbench for two_level_round_robin_scheduler_core.
// Uses trrs_pkg; an in-bench scheduler model predicts each response. Directed
// load/grant phases run first, then random ones under varied idle and stall mixes.
module two_level_round_robin_scheduler_core_tb;
	import trrs_pkg::*;

	localparam int N_ENTRIES = 32;
	localparam int RANDOM_ITEMS = 950;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_GRANTS_PER_PHASE = 60;
	localparam int REQ_W = $bits(req_t);
	localparam int COUNT_PAD_W = CFG_DATA_W - COUNT_FIELD_W;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// scheduler model state, indexed by class
	logic [TIME_FIELD_W-1:0] remaining [2][N_ENTRIES] = '{default: '0};
	logic [INDEX_FIELD_W-1:0] next_idx [2] = '{default: '0};
	logic [TIME_FIELD_W-1:0] quantum = 16'd1;
	logic [COUNT_FIELD_W-1:0] cnt_high = '0;
	logic [COUNT_FIELD_W-1:0] cnt_low = '0;

	req_t pending_reqs [$];
	rsp_t predicted_rsps [$];

	int send_idle_pct = 0;
	int rcv_stall_pct = 0;
	int n_queued = 0;
	int n_loads = 0;
	int n_grants = 0;
	int n_finished = 0;
	int n_all_done = 0;
	int n_phases = 0;
	int errors = 0;
	int cycles = 0;

	two_level_round_robin_scheduler_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_quantum();
		return (quantum == 0) ? 1 : int'(quantum);
	endfunction

	function automatic int active_count(input logic cls);
		int n;
		n = (cls == CLASS_HIGH) ? int'(cnt_high) : int'(cnt_low);
		return (n > N_ENTRIES) ? N_ENTRIES : n;
	endfunction

	function automatic int turns_left(input int t, input int q);
		return (t + q - 1) / q;
	endfunction

	// one round-robin pick from a table; updates the table and its pointer
	function automatic bit grant_from(input logic cls, output logic [INDEX_FIELD_W-1:0] idx,
			output logic [TIME_FIELD_W-1:0] amt, output logic fin);
		int cnt, start, e, q;
		cnt = active_count(cls);
		q = eff_quantum();
		idx = '0;
		amt = '0;
		fin = 1'b0;
		if (cnt == 0)
			return 1'b0;
		start = (int'(next_idx[cls]) < cnt) ? int'(next_idx[cls]) : 0;
		for (int k = 0; k < cnt; k++) begin
			e = (start + k) % cnt;
			if (remaining[cls][e] != 0) begin
				if (int'(remaining[cls][e]) > q) begin
					amt = q[TIME_FIELD_W-1:0];
					remaining[cls][e] = remaining[cls][e] - q[TIME_FIELD_W-1:0];
				end else begin
					amt = remaining[cls][e];
					remaining[cls][e] = '0;
					fin = 1'b1;
				end
				idx = e[INDEX_FIELD_W-1:0];
				next_idx[cls] = (e + 1 < cnt) ? e[INDEX_FIELD_W-1:0] + 1'b1 : '0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit table_clear(input logic cls);
		for (int i = 0; i < active_count(cls); i++)
			if (remaining[cls][i] != 0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic rsp_t predict_rsp(input req_t r);
		rsp_t o;
		logic [INDEX_FIELD_W-1:0] idx;
		logic [TIME_FIELD_W-1:0] amt;
		logic fin;
		o = '0;
		if (r.command == CMD_LOAD) begin
			remaining[r.priority_class][r.process_index] = r.burst_time;
		end else if (grant_from(CLASS_HIGH, idx, amt, fin)) begin
			o.grant_valid = 1'b1;
			o.granted_class = CLASS_HIGH;
			o.granted_index = idx;
			o.granted_time = amt;
			o.finished = fin;
		end else if (grant_from(CLASS_LOW, idx, amt, fin)) begin
			o.grant_valid = 1'b1;
			o.granted_class = CLASS_LOW;
			o.granted_index = idx;
			o.granted_time = amt;
			o.finished = fin;
		end
		o.all_done = table_clear(CLASS_HIGH) && table_clear(CLASS_LOW);
		return o;
	endfunction

	function automatic string fmt_rsp(input rsp_t r);
		return $sformatf("valid=%0b class=%0b index=%0d time=%0d finished=%0b all_done=%0b",
			r.grant_valid, r.granted_class, r.granted_index, r.granted_time,
			r.finished, r.all_done);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				predicted_rsps.push_back(predict_rsp(req));
				if (req.command == CMD_LOAD)
					n_loads++;
				else
					n_grants++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsps.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response: %s", fmt_rsp(rsp));
				end else begin
					want = predicted_rsps.pop_front();
					if (rsp.grant_valid !== want.grant_valid
							|| rsp.granted_class !== want.granted_class
							|| rsp.granted_index !== want.granted_index
							|| rsp.granted_time !== want.granted_time
							|| rsp.finished !== want.finished
							|| rsp.all_done !== want.all_done) begin
						errors++;
						if (errors <= 10)
							$display("mismatch at cycle %0d\n  expected %s\n  actual   %s",
								cycles, fmt_rsp(want), fmt_rsp(rsp));
					end
					if (want.finished)
						n_finished++;
					if (want.all_done)
						n_all_done++;
				end
			end
			rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycles,
				predicted_rsps.size());
			$display("two_level_round_robin_scheduler_core_tb failed");
			$finish;
		end
	end

	task automatic push_load(input logic cls, input logic [INDEX_FIELD_W-1:0] idx,
			input logic [TIME_FIELD_W-1:0] burst);
		req_t r;
		r.command = CMD_LOAD;
		r.priority_class = cls;
		r.process_index = idx;
		r.burst_time = burst;
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	// grant request; the other fields are don't-care and get random content
	task automatic push_grant();
		req_t r;
		r = req_t'(REQ_W'($urandom));
		r.command = CMD_GRANT;
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_TIME_SLICE: quantum = val;
			REG_HIGH_COUNT: cnt_high = val[COUNT_FIELD_W-1:0];
			REG_LOW_COUNT: cnt_low = val[COUNT_FIELD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic cfg_release();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || req_valid || predicted_rsps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_slice();
		case ($urandom_range(7))
			0: return '0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return CFG_DATA_W'($urandom);
			default: return CFG_DATA_W'($urandom_range(2, 8));
		endcase
	endfunction

	// count with occasional junk in the bits above the register width
	function automatic logic [CFG_DATA_W-1:0] pick_count();
		logic [CFG_DATA_W-1:0] v;
		case ($urandom_range(7))
			0: v = '0;
			1: v = 16'd32;
			2: v = CFG_DATA_W'($urandom_range(33, 63));
			default: v = CFG_DATA_W'($urandom_range(1, 31));
		endcase
		if ($urandom_range(3) == 0)
			v[CFG_DATA_W-1:COUNT_FIELD_W] = COUNT_PAD_W'($urandom >> 4);
		return v;
	endfunction

	function automatic logic [TIME_FIELD_W-1:0] pick_burst(input int q);
		int b;
		if ($urandom_range(9) == 0)
			return TIME_FIELD_W'($urandom);
		b = q * int'($urandom_range(0, 4)) + int'($urandom_range(0, q));
		return (b > 65535) ? 16'hFFFF : b[TIME_FIELD_W-1:0];
	endfunction

	// new settings, then loads followed or interleaved with grants for the planned work, capped at MAX_GRANTS_PER_PHASE
	task automatic random_phase();
		int q, need, ngrant;
		int plan [2][N_ENTRIES];
		int cnt [2];
		bit mixed;
		logic cls;
		logic [INDEX_FIELD_W-1:0] idx;
		req_t loads [$];
		req_t r;
		if ($urandom_range(3) != 0)
			write_reg(REG_TIME_SLICE, pick_slice());
		if ($urandom_range(3) != 0)
			write_reg(REG_HIGH_COUNT, pick_count());
		if ($urandom_range(3) != 0)
			write_reg(REG_LOW_COUNT, pick_count());
		if ($urandom_range(5) == 0)
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_release();
		q = eff_quantum();
		cnt[CLASS_HIGH] = active_count(CLASS_HIGH);
		cnt[CLASS_LOW] = active_count(CLASS_LOW);
		for (int c = 0; c < 2; c++)
			for (int i = 0; i < N_ENTRIES; i++)
				plan[c][i] = int'(remaining[c][i]);
		// retire leftovers that would take too many turns at this slice
		for (int c = 0; c < 2; c++)
			for (int i = 0; i < cnt[c]; i++)
				if (turns_left(plan[c][i], q) > 6) begin
					push_load(c[0], i[INDEX_FIELD_W-1:0], '0);
					plan[c][i] = 0;
				end
		repeat ($urandom_range(1, 10)) begin
			cls = 1'($urandom_range(1));
			if (cnt[cls] > 0 && $urandom_range(3) != 0)
				idx = INDEX_FIELD_W'($urandom_range(0, cnt[cls] - 1));
			else
				idx = INDEX_FIELD_W'($urandom_range(0, N_ENTRIES - 1));
			r.command = CMD_LOAD;
			r.priority_class = cls;
			r.process_index = idx;
			r.burst_time = pick_burst(q);
			plan[cls][idx] = int'(r.burst_time);
			loads.push_back(r);
		end
		need = 0;
		for (int c = 0; c < 2; c++)
			for (int i = 0; i < cnt[c]; i++)
				need += turns_left(plan[c][i], q);
		ngrant = ((need > MAX_GRANTS_PER_PHASE) ? MAX_GRANTS_PER_PHASE : need)
			+ int'($urandom_range(0, 3));
		mixed = 1'($urandom_range(1));
		while (loads.size() != 0 || ngrant > 0) begin
			if ($urandom_range(9) == 0)
				push_load(1'($urandom_range(1)),
					INDEX_FIELD_W'($urandom_range(0, N_ENTRIES - 1)),
					TIME_FIELD_W'($urandom));
			if (loads.size() != 0 && (!mixed || ngrant == 0 || $urandom_range(1))) begin
				pending_reqs.push_back(loads.pop_front());
				n_queued++;
			end else begin
				push_grant();
				ngrant--;
			end
		end
	endtask

	initial begin
		int phase;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty grant, load into a table whose count is zero
		push_grant();
		push_load(CLASS_HIGH, 5'd0, 16'd2);
		push_grant();
		drain();

		// zero slice acts as one; high count above table size saturates
		write_reg(REG_TIME_SLICE, 16'd0);
		write_reg(REG_HIGH_COUNT, 16'd63);
		write_reg(REG_LOW_COUNT, 16'd32);
		cfg_release();
		push_load(CLASS_HIGH, 5'd31, 16'd3);
		push_load(CLASS_LOW, 5'd0, 16'd1);
		push_load(CLASS_HIGH, 5'd5, 16'd0);
		repeat (7) push_grant();
		drain();

		// full slice, max burst; low entry beyond its count stays hidden
		write_reg(REG_TIME_SLICE, 16'hFFFF);
		write_reg(REG_HIGH_COUNT, 16'd4);
		write_reg(REG_LOW_COUNT, 16'd2);
		cfg_release();
		push_load(CLASS_HIGH, 5'd1, 16'hFFFF);
		push_load(CLASS_LOW, 5'd31, 16'd7);
		push_grant();
		push_grant();
		drain();

		// high pointer now past the shrunken count; low count uncovers entry 31
		write_reg(REG_TIME_SLICE, 16'd2);
		write_reg(REG_HIGH_COUNT, 16'd1);
		write_reg(REG_LOW_COUNT, 16'd32);
		cfg_release();
		push_load(CLASS_HIGH, 5'd0, 16'd3);
		repeat (7) push_grant();
		drain();

		phase = 0;
		while (n_queued < 25 + RANDOM_ITEMS) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; rcv_stall_pct = 0; end
				1: begin send_idle_pct = 46; rcv_stall_pct = 0; end
				2: begin send_idle_pct = 0; rcv_stall_pct = 46; end
				default: begin send_idle_pct = 18; rcv_stall_pct = 18; end
			endcase
			random_phase();
			drain();
			phase++;
		end
		n_phases = phase;

		$display("covered %0d loads and %0d grant requests over %0d random phases",
			n_loads, n_grants, n_phases);
		$display("%0d grants finished a process, %0d responses saw both tables empty",
			n_finished, n_all_done);
		if (errors == 0 && predicted_rsps.size() == 0)
			$display("two_level_round_robin_scheduler_core_tb passed");
		else
			$display("two_level_round_robin_scheduler_core_tb failed");
		$finish;
	end

endmodule

// ===== two_level_round_robin_scheduler_core.f =====
src/trrs_pkg.sv
src/trrs_ram.sv
src/two_level_round_robin_scheduler_core.sv
test/two_level_round_robin_scheduler_core_tb.sv
